@@ sv/rps_pkg.sv @@
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, codes and constants of the rail profile sweep mesh block.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam int CFG_W          = 21;
   localparam int NUM_FACE       = 18;

   // request codes
   localparam logic [1:0] REQ_PRIME  = 2'd0;
   localparam logic [1:0] REQ_SLICE  = 2'd1;
   localparam logic [1:0] REQ_FACES  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_HALF_SEP    = 2'd0;
   localparam logic [1:0] CSR_RAIL_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_RAIL_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_UV_SCALE    = 2'd3;

   localparam logic [CFG_W-1:0] HALF_SEP_RST    = 21'd16384;
   localparam logic [CFG_W-1:0] RAIL_WIDTH_RST  = 21'd6554;
   localparam logic [CFG_W-1:0] RAIL_HEIGHT_RST = 21'd9830;
   localparam logic [CFG_W-1:0] UV_SCALE_RST    = 21'd65536;

   // result kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   localparam logic [3:0] FACE_OFFSETS [NUM_FACE] = '{
      4'd8, 4'd0, 4'd1,  4'd8, 4'd1, 4'd9,  4'd9, 4'd1, 4'd2,
      4'd9, 4'd2, 4'd10, 4'd10, 4'd2, 4'd3, 4'd10, 4'd3, 4'd11};

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        path_dist;
   } rps_req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic [1:0]         tex_u_code;
      logic signed [31:0] tex_v;
      logic [15:0]        vertex_index;
      logic               last;
   } rps_rsp_type;

   typedef enum logic {
      RD_ROOT,
      RD_DIV
   } rps_rd_op_type;

   typedef struct packed {
      logic          start;
      rps_rd_op_type op;
   } rps_rd_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SHIFT,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_NORM_DONE,
      ST_CROSS,
      ST_SCALE,
      ST_PREP_A,
      ST_PREP_B,
      ST_EMIT
   } rps_state_type;

   typedef enum logic [1:0] {
      PASS_DIR,
      PASS_SIDE,
      PASS_NRM
   } rps_pass_type;

   // texture u code of each vertex of a slice
   function automatic logic [1:0] ucode(input logic [2:0] k);
      logic [1:0] c;
      c = k[2] ? ~k[1:0] : k[1:0];
      return c;
   endfunction

endpackage

@@ sv/rps_root_div.sv @@
// ----------------------------------------------------------------------------
// rps_root_div
// Iterative square root / rounded divide unit, one bit per cycle on a shared
// subtractor.
// ----------------------------------------------------------------------------
module rps_root_div (
   input  logic                    clock,
   input  logic                    reset,
   input  rps_pkg::rps_rd_cmd_type cmd,
   input  logic [61:0]             opnd,
   input  logic [31:0]             divisor,
   output logic                    done,
   output logic [31:0]             result
);
   import rps_pkg::*;

   logic [61:0]   acc_ff, acc_in;
   logic [61:0]   res_ff, res_in;
   logic [17:0]   num_ff, num_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   rps_rd_op_type op_ff, op_in;

   logic [61:0] bit_val;
   logic [32:0] shl;
   logic [63:0] opa, opb, diff;
   logic        fits;
   logic [46:0] numer;

   assign bit_val = 62'(1) << {cnt_ff, 1'b0};
   assign shl     = {acc_ff[31:0], num_ff[17]};
   assign numer   = {1'b0, opnd[29:0], 16'b0} + 47'(divisor[31:1]);

   always_comb begin
      if (op_ff == RD_ROOT) begin
         opa = 64'(acc_ff);
         opb = 64'(res_ff) + 64'(bit_val);
      end else begin
         opa = 64'(shl);
         opb = 64'(divisor);
      end
   end

   // one shared subtractor for both operations
   assign diff = opa - opb;
   assign fits = ~diff[63];

   always_comb begin
      acc_in  = acc_ff;
      res_in  = res_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         res_in  = '0;
         if (cmd.op == RD_ROOT) begin
            acc_in = opnd;
            num_in = '0;
            cnt_in = 5'd30;
         end else begin
            acc_in = 62'(numer[46:18]);
            num_in = numer[17:0];
            cnt_in = 5'd17;
         end
      end else if (busy_ff) begin
         if (op_ff == RD_ROOT) begin
            if (fits) begin
               acc_in = diff[61:0];
               res_in = (res_ff >> 1) + bit_val;
            end else begin
               res_in = res_ff >> 1;
            end
         end else begin
            num_in = {num_ff[16:0], 1'b0};
            if (fits) begin
               acc_in = 62'(diff[31:0]);
               res_in = {res_ff[60:0], 1'b1};
            end else begin
               acc_in = 62'(shl[31:0]);
               res_in = {res_ff[60:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      res_ff <= res_in;
      num_ff <= num_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff[31:0];

endmodule

@@ sv/rail_profile_sweep_mesh_top.sv @@
// ----------------------------------------------------------------------------
// rail_profile_sweep_mesh_top
// Sweeps a two rail profile along a path of Q16.16 points into mesh words.
// ----------------------------------------------------------------------------
// Input words arrive on req_valid/req_ready, result words leave on
// rsp_valid/rsp_ready; registers are written through csr_we/csr_index/
// csr_data, by the user only while the block is idle; the block itself
// does not enforce this. A prime word or an unused request code is taken
// and gives no result. A slice runs three vector normalizations one after
// another on a shared multiplier and an iterative root/divide unit. Each
// normalization shifts the vector one bit per cycle until its largest
// magnitude lies in [2^29, 2^30), sums the squares, takes the root and
// divides each component by it. A zero vector skips its normalization.
// Cross product, scaling and vertex setup come on top; then 8 vertex words
// (44 with faces) leave at one per cycle while the receiver takes them.
// req_ready is high only while no word is at work.
// Results sit in an output register; when the receiver stalls the
// sequencer waits. Reset restores the register defaults, clears the
// previous point and the vertex counter and empties the output register.
// ----------------------------------------------------------------------------
module rail_profile_sweep_mesh_top #(
   parameter int INDEX_BITS = rps_pkg::INDEX_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rps_pkg::rps_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rps_pkg::rps_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [20:0]          csr_data
);
   import rps_pkg::*;

   localparam int IW = INDEX_BITS;

   rps_state_type state_ff, state_in;
   rps_pass_type  pass_ff, pass_in;
   logic [3:0]    step_ff, step_in;
   logic [5:0]    emit_ff, emit_in;

   logic [CFG_W-1:0] sep_ff, sep_in, wid_ff, wid_in, hgt_ff, hgt_in, uvs_ff, uvs_in;

   logic [1:0]         typ_ff, typ_in;
   logic signed [31:0] pnt_ff [3];
   logic signed [31:0] pnt_in [3];
   logic [30:0]        pp_ff, pp_in;
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] prev_in [3];
   logic [IW-1:0]      cnt_ff, cnt_in;

   logic signed [35:0] vec_ff [3];
   logic signed [35:0] vec_in [3];
   logic [35:0]        mag_ff [3];
   logic [35:0]        mag_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic [61:0]        sum_ff, sum_in;
   logic [31:0]        len_ff, len_in;
   logic signed [17:0] uvec_ff [3];
   logic signed [17:0] uvec_in [3];
   logic signed [17:0] dir_ff [3];
   logic signed [17:0] dir_in [3];
   logic signed [17:0] side_ff [3];
   logic signed [17:0] side_in [3];
   logic signed [17:0] nrm_ff [3];
   logic signed [17:0] nrm_in [3];

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in;

   logic signed [31:0] sepv_ff [3];
   logic signed [31:0] sepv_in [3];
   logic signed [31:0] widv_ff [3];
   logic signed [31:0] widv_in [3];
   logic signed [31:0] hgtv_ff [3];
   logic signed [31:0] hgtv_in [3];
   logic [30:0]        tv_ff, tv_in;
   logic signed [31:0] bv_ff [4][3];
   logic signed [31:0] bv_in [4][3];

   rps_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   rps_rd_cmd_type rd_cmd;
   logic [61:0]    rd_opnd;
   logic           rd_done;
   logic [31:0]    rd_result;

   logic signed [31:0] req_pos [3];
   logic               vec_zero, mag_hi, mag_lo_ok;
   logic               can_load;
   logic signed [17:0] scl_src;
   logic [17:0]        scl_mag;
   logic [CFG_W-1:0]   scl_cfg;
   logic               cons_neg;
   logic [52:0]        rnd;
   logic [20:0]        rnd_small;
   logic signed [31:0] scl_val;
   logic [17:0]        quo;

   logic [2:0]    vk;
   logic [1:0]    bsel;
   logic          addh;
   logic [5:0]    fj;
   logic          half;
   logic [4:0]    fi;
   logic [IW-1:0] face_idx, vert_idx;
   logic [31:0]   idx_wide;
   logic          is_face, last_now;
   rps_rsp_type   rsp_next;

   rps_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rd_cmd),
      .opnd    (rd_opnd),
      .divisor (len_ff),
      .done    (rd_done),
      .result  (rd_result)
   );

   assign req_pos[0] = req_data.pos_x;
   assign req_pos[1] = req_data.pos_y;
   assign req_pos[2] = req_data.pos_z;

   assign vec_zero  = (vec_ff[0] == '0) && (vec_ff[1] == '0) && (vec_ff[2] == '0);
   assign mag_hi    = (|mag_ff[0][35:30]) | (|mag_ff[1][35:30]) | (|mag_ff[2][35:30]);
   assign mag_lo_ok = mag_ff[0][29] | mag_ff[1][29] | mag_ff[2][29];
   assign can_load  = ~rsp_valid_ff | rsp_ready;
   assign quo       = rd_result[17:0];

   // ---------------- result word builder
   assign vk      = emit_ff[2:0];
   assign bsel    = vk[2:1];
   assign addh    = (vk == 3'd1) || (vk == 3'd2) || (vk == 3'd5) || (vk == 3'd6);
   assign is_face = emit_ff >= 6'd8;
   assign fj      = emit_ff - 6'd8;
   assign half    = fj >= 6'd18;
   assign fi      = half ? 5'(fj - 6'd18) : fj[4:0];

   assign vert_idx = cnt_ff + IW'(vk);
   assign face_idx = cnt_ff - IW'(8) + (half ? IW'(4) : IW'(0)) + IW'(FACE_OFFSETS[fi]);
   assign idx_wide = is_face ? 32'(face_idx) : 32'(vert_idx);
   assign last_now = is_face ? (emit_ff == 6'd43) : ((vk == 3'd7) && (typ_ff != REQ_FACES));

   always_comb begin
      rsp_next              = '0;
      rsp_next.vertex_index = idx_wide[15:0];
      rsp_next.last         = last_now;
      if (is_face) begin
         rsp_next.kind = KIND_INDEX;
      end else begin
         rsp_next.kind       = KIND_VERTEX;
         rsp_next.vert_x     = bv_ff[bsel][0] + (addh ? hgtv_ff[0] : 32'sd0);
         rsp_next.vert_y     = bv_ff[bsel][1] + (addh ? hgtv_ff[1] : 32'sd0);
         rsp_next.vert_z     = bv_ff[bsel][2] + (addh ? hgtv_ff[2] : 32'sd0);
         rsp_next.tex_u_code = ucode(vk);
         rsp_next.tex_v      = {1'b0, tv_ff};
      end
   end

   // ---------------- multiplier operands
   always_comb begin
      scl_src = '0;
      scl_cfg = '0;
      case (step_ff)
         4'd0: begin scl_src = side_ff[0]; scl_cfg = sep_ff; end
         4'd1: begin scl_src = side_ff[1]; scl_cfg = sep_ff; end
         4'd2: begin scl_src = side_ff[2]; scl_cfg = sep_ff; end
         4'd3: begin scl_src = side_ff[0]; scl_cfg = wid_ff; end
         4'd4: begin scl_src = side_ff[1]; scl_cfg = wid_ff; end
         4'd5: begin scl_src = side_ff[2]; scl_cfg = wid_ff; end
         4'd6: begin scl_src = nrm_ff[0]; scl_cfg = hgt_ff; end
         4'd7: begin scl_src = nrm_ff[1]; scl_cfg = hgt_ff; end
         4'd8: begin scl_src = nrm_ff[2]; scl_cfg = hgt_ff; end
         default: begin scl_src = '0; scl_cfg = uvs_ff; end
      endcase
   end

   assign scl_mag = scl_src[17] ? 18'(-scl_src) : 18'(scl_src);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQUARE: begin
            if (step_ff < 4'd3) begin
               mul_a = 33'(mag_ff[step_ff[1:0]][29:0]);
               mul_b = 33'(mag_ff[step_ff[1:0]][29:0]);
            end
         end
         ST_CROSS: begin
            case (step_ff)
               4'd0: begin mul_a = 33'(side_ff[1]); mul_b = 33'(dir_ff[2]); end
               4'd1: begin mul_a = 33'(side_ff[2]); mul_b = 33'(dir_ff[1]); end
               4'd2: begin mul_a = 33'(side_ff[2]); mul_b = 33'(dir_ff[0]); end
               4'd3: begin mul_a = 33'(side_ff[0]); mul_b = 33'(dir_ff[2]); end
               4'd4: begin mul_a = 33'(side_ff[0]); mul_b = 33'(dir_ff[1]); end
               4'd5: begin mul_a = 33'(side_ff[1]); mul_b = 33'(dir_ff[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_SCALE: begin
            if (step_ff == 4'd9) begin
               mul_a = 33'(pp_ff);
            end else begin
               mul_a = 33'(scl_mag);
            end
            mul_b = 33'(scl_cfg);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sign of the scaled component that the product register now holds
   always_comb begin
      case (step_ff)
         4'd1: cons_neg = side_ff[0][17];
         4'd2: cons_neg = side_ff[1][17];
         4'd3: cons_neg = side_ff[2][17];
         4'd4: cons_neg = side_ff[0][17];
         4'd5: cons_neg = side_ff[1][17];
         4'd6: cons_neg = side_ff[2][17];
         4'd7: cons_neg = nrm_ff[0][17];
         4'd8: cons_neg = nrm_ff[1][17];
         4'd9: cons_neg = nrm_ff[2][17];
         default: cons_neg = 1'b0;
      endcase
   end

   assign rnd       = prod_ff[52:0] + 53'd32768;
   assign rnd_small = rnd[36:16];
   assign scl_val   = cons_neg ? -32'(rnd_small) : 32'(rnd_small);

   // ---------------- root/divide commands
   always_comb begin
      rd_cmd.start = (state_ff == ST_ROOT_GO) || (state_ff == ST_DIV_GO);
      rd_cmd.op    = (state_ff == ST_ROOT_GO) ? RD_ROOT : RD_DIV;
      rd_opnd      = (state_ff == ST_ROOT_GO) ? sum_ff : 62'(mag_ff[step_ff[1:0]][29:0]);
   end

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.req_type)
                  REQ_SLICE, REQ_FACES: state_in = ST_LOAD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:      state_in = vec_zero ? ST_NORM_DONE : ST_SHIFT;
         ST_SHIFT: begin
            if (!mag_hi && mag_lo_ok) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (step_ff == 4'd3) state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: begin
            if (rd_done) state_in = ST_DIV_GO;
         end
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (rd_done) state_in = (step_ff == 4'd2) ? ST_NORM_DONE : ST_DIV_GO;
         end
         ST_NORM_DONE: begin
            case (pass_ff)
               PASS_DIR:  state_in = ST_LOAD;
               PASS_SIDE: state_in = ST_CROSS;
               default:   state_in = ST_SCALE;
            endcase
         end
         ST_CROSS: begin
            if (step_ff == 4'd6) state_in = ST_LOAD;
         end
         ST_SCALE: begin
            if (step_ff == 4'd10) state_in = ST_PREP_A;
         end
         ST_PREP_A:    state_in = ST_PREP_B;
         ST_PREP_B:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (can_load && last_now) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and outputs
   always_comb begin
      pass_in      = pass_ff;
      step_in      = step_ff;
      emit_in      = emit_ff;
      sep_in       = sep_ff;
      wid_in       = wid_ff;
      hgt_in       = hgt_ff;
      uvs_in       = uvs_ff;
      typ_in       = typ_ff;
      pp_in        = pp_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      tv_in        = tv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      for (int i = 0; i < 3; i++) begin
         pnt_in[i]  = pnt_ff[i];
         prev_in[i] = prev_ff[i];
         vec_in[i]  = vec_ff[i];
         mag_in[i]  = mag_ff[i];
         uvec_in[i] = uvec_ff[i];
         dir_in[i]  = dir_ff[i];
         side_in[i] = side_ff[i];
         nrm_in[i]  = nrm_ff[i];
         sepv_in[i] = sepv_ff[i];
         widv_in[i] = widv_ff[i];
         hgtv_in[i] = hgtv_ff[i];
         for (int b = 0; b < 4; b++) begin
            bv_in[b][i] = bv_ff[b][i];
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_HALF_SEP:    sep_in = csr_data;
            CSR_RAIL_WIDTH:  wid_in = csr_data;
            CSR_RAIL_HEIGHT: hgt_in = csr_data;
            CSR_UV_SCALE:    uvs_in = csr_data;
            default:         sep_in = sep_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               typ_in  = req_data.req_type;
               pp_in   = req_data.path_dist;
               pass_in = PASS_DIR;
               step_in = '0;
               for (int i = 0; i < 3; i++) begin
                  pnt_in[i] = req_pos[i];
                  vec_in[i] = 36'(req_pos[i]) - 36'(prev_ff[i]);
               end
               if (req_data.req_type == REQ_PRIME) begin
                  for (int i = 0; i < 3; i++) prev_in[i] = req_pos[i];
               end
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i]  = vec_ff[i][35];
               mag_in[i]  = vec_ff[i][35] ? 36'(-vec_ff[i]) : 36'(vec_ff[i]);
               uvec_in[i] = '0;
            end
         end
         ST_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            for (int i = 0; i < 3; i++) begin
               if (mag_hi) mag_in[i] = mag_ff[i] >> 1;
               else if (!mag_lo_ok) mag_in[i] = mag_ff[i] << 1;
            end
            step_in = '0;
         end
         ST_SQUARE: begin
            sum_in  = (step_ff == 4'd0) ? '0 : sum_ff + prod_ff[61:0];
            step_in = (step_ff == 4'd3) ? 4'd0 : step_ff + 4'd1;
         end
         ST_ROOT_WAIT: begin
            if (rd_done) len_in = rd_result;
            step_in = '0;
         end
         ST_DIV_WAIT: begin
            if (rd_done) begin
               uvec_in[step_ff[1:0]] = neg_ff[step_ff[1:0]] ? 18'(-quo) : 18'(quo);
               step_in = (step_ff == 4'd2) ? 4'd0 : step_ff + 4'd1;
            end
         end
         ST_NORM_DONE: begin
            step_in = '0;
            case (pass_ff)
               PASS_DIR: begin
                  for (int i = 0; i < 3; i++) dir_in[i] = uvec_ff[i];
                  vec_in[0] = -36'(uvec_ff[2]);
                  vec_in[1] = '0;
                  vec_in[2] = 36'(uvec_ff[0]);
                  pass_in   = PASS_SIDE;
               end
               PASS_SIDE: begin
                  for (int i = 0; i < 3; i++) side_in[i] = uvec_ff[i];
                  pass_in = PASS_NRM;
               end
               default: begin
                  for (int i = 0; i < 3; i++) nrm_in[i] = uvec_ff[i];
               end
            endcase
         end
         ST_CROSS: begin
            case (step_ff)
               4'd1: vec_in[0] = prod_ff[35:0];
               4'd2: vec_in[0] = vec_ff[0] - prod_ff[35:0];
               4'd3: vec_in[1] = prod_ff[35:0];
               4'd4: vec_in[1] = vec_ff[1] - prod_ff[35:0];
               4'd5: vec_in[2] = prod_ff[35:0];
               4'd6: vec_in[2] = vec_ff[2] - prod_ff[35:0];
               default: vec_in[0] = vec_ff[0];
            endcase
            step_in = (step_ff == 4'd6) ? 4'd0 : step_ff + 4'd1;
         end
         ST_SCALE: begin
            case (step_ff)
               4'd1: sepv_in[0] = scl_val;
               4'd2: sepv_in[1] = scl_val;
               4'd3: sepv_in[2] = scl_val;
               4'd4: widv_in[0] = scl_val;
               4'd5: widv_in[1] = scl_val;
               4'd6: widv_in[2] = scl_val;
               4'd7: hgtv_in[0] = scl_val;
               4'd8: hgtv_in[1] = scl_val;
               4'd9: hgtv_in[2] = scl_val;
               4'd10: tv_in = (|rnd[52:47]) ? 31'h7FFF_FFFF : rnd[46:16];
               default: tv_in = tv_ff;
            endcase
            step_in = (step_ff == 4'd10) ? 4'd0 : step_ff + 4'd1;
         end
         ST_PREP_A: begin
            for (int i = 0; i < 3; i++) begin
               bv_in[1][i] = pnt_ff[i] - sepv_ff[i];
               bv_in[2][i] = pnt_ff[i] + sepv_ff[i];
            end
         end
         ST_PREP_B: begin
            for (int i = 0; i < 3; i++) begin
               bv_in[0][i] = bv_ff[1][i] - widv_ff[i];
               bv_in[3][i] = bv_ff[2][i] + widv_ff[i];
            end
            emit_in = '0;
         end
         ST_EMIT: begin
            if (can_load) begin
               rsp_in       = rsp_next;
               rsp_valid_in = 1'b1;
               emit_in      = emit_ff + 6'd1;
               if (last_now) begin
                  cnt_in = cnt_ff + IW'(8);
                  for (int i = 0; i < 3; i++) prev_in[i] = pnt_ff[i];
               end
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      typ_ff  <= typ_in;
      pp_ff   <= pp_in;
      neg_ff  <= neg_in;
      sum_ff  <= sum_in;
      len_ff  <= len_in;
      tv_ff   <= tv_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < 3; i++) begin
         pnt_ff[i]  <= pnt_in[i];
         vec_ff[i]  <= vec_in[i];
         mag_ff[i]  <= mag_in[i];
         uvec_ff[i] <= uvec_in[i];
         dir_ff[i]  <= dir_in[i];
         side_ff[i] <= side_in[i];
         nrm_ff[i]  <= nrm_in[i];
         sepv_ff[i] <= sepv_in[i];
         widv_ff[i] <= widv_in[i];
         hgtv_ff[i] <= hgtv_in[i];
         for (int b = 0; b < 4; b++) begin
            bv_ff[b][i] <= bv_in[b][i];
         end
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_DIR;
         step_ff      <= '0;
         emit_ff      <= '0;
         sep_ff       <= HALF_SEP_RST;
         wid_ff       <= RAIL_WIDTH_RST;
         hgt_ff       <= RAIL_HEIGHT_RST;
         uvs_ff       <= UV_SCALE_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) prev_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         sep_ff       <= sep_in;
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
         uvs_ff       <= uvs_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) prev_ff[i] <= prev_in[i];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
